[rtl/tile_frustum_cull_and_lod_select_top_assert.svh]
// Assertion macros shared by the tile cull block.
// Each macro expects clk and rst to be visible where it is used.
`ifndef TILE_FRUSTUM_CULL_AND_LOD_SELECT_TOP_ASSERT_SVH
`define TILE_FRUSTUM_CULL_AND_LOD_SELECT_TOP_ASSERT_SVH

// Same-cycle implication.
`define TFC_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfc assertion failed");

// Next-cycle implication.
`define TFC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfc assertion failed");

`endif

[rtl/tfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_pkg
// Constants, widths and types shared by the tile cull and detail select block.
// ----------------------------------------------------------------------------
package tfc_pkg;

  localparam int TILE_WORLD_SIZE = 256;
  localparam int BOX_HALF_HEIGHT = 40;
  localparam int LOD_RADIUS      = 2;

  localparam int TILE_W    = 12;
  localparam int NORM_W    = 12;
  localparam int OFFSET_W  = 28;
  localparam int PLANE_W   = 64;
  localparam int CFG_IDX_W = 3;

  // Plane register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    LEFT_PLANE,
    RIGHT_PLANE,
    BOTTOM_PLANE,
    TOP_PLANE,
    NEAR_PLANE,
    FAR_PLANE
  } plane_idx_t;

  localparam int PLANE_COUNT = int'(FAR_PLANE) + 1;

  // Positions are held doubled so that the box edges are integers.
  localparam int SIZE_W  = $clog2(TILE_WORLD_SIZE) + 1;
  localparam int COORD_W = TILE_W + 2 + SIZE_W;
  localparam int PROD_W  = COORD_W + NORM_W;
  localparam int SUM_W   = PROD_W + 3;
  localparam int DIFF_W  = TILE_W + 1;

  localparam logic signed [COORD_W-1:0] TILE_SIZE_C = COORD_W'(TILE_WORLD_SIZE);
  localparam logic signed [COORD_W-1:0] COORD_ONE   = COORD_W'(1);
  localparam logic signed [PROD_W-1:0]  BOX_Y_MAX   = PROD_W'(2 * BOX_HALF_HEIGHT);
  localparam logic signed [PROD_W-1:0]  BOX_Y_MIN   = PROD_W'(-2 * BOX_HALF_HEIGHT);
  localparam logic signed [SUM_W-1:0]   CULL_LIMIT  = SUM_W'(-(TILE_WORLD_SIZE * 512));
  localparam logic signed [DIFF_W-1:0]  LOD_HI      = DIFF_W'(LOD_RADIUS);
  localparam logic signed [DIFF_W-1:0]  LOD_LO      = DIFF_W'(-LOD_RADIUS);

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_z;
  } box_t;

endpackage

[rtl/tfc_box_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_box_stage
// Input register: builds the tile's doubled x/z box edges and the detail flag.
// ----------------------------------------------------------------------------
module tfc_box_stage
  import tfc_pkg::*;
(
  input  logic                     clk,
  input  logic                     load,
  input  logic signed [TILE_W-1:0] tile_x,
  input  logic signed [TILE_W-1:0] tile_z,
  input  logic signed [TILE_W-1:0] camera_tile_x,
  input  logic signed [TILE_W-1:0] camera_tile_z,
  output box_t                     box,
  output logic                     near_cam
);

  logic signed [COORD_W-1:0] tx_e;
  logic signed [COORD_W-1:0] tz_e;
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dz;
  box_t                      box_next;
  logic                      near_cam_next;

  always_comb begin
    tx_e = COORD_W'(tile_x);
    tz_e = COORD_W'(tile_z);
    box_next.min_x = ((tx_e <<< 1) - COORD_ONE) * TILE_SIZE_C;
    box_next.max_x = ((tx_e <<< 1) + COORD_ONE) * TILE_SIZE_C;
    box_next.min_z = ((tz_e <<< 1) - COORD_ONE) * TILE_SIZE_C;
    box_next.max_z = ((tz_e <<< 1) + COORD_ONE) * TILE_SIZE_C;
    dx = DIFF_W'(tile_x) - DIFF_W'(camera_tile_x);
    dz = DIFF_W'(tile_z) - DIFF_W'(camera_tile_z);
    near_cam_next = (dx >= LOD_LO) && (dx <= LOD_HI) && (dz >= LOD_LO) && (dz <= LOD_HI);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      box      <= box_next;
      near_cam <= near_cam_next;
    end
  end

endmodule

[rtl/tfc_plane_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfc_plane_lane
// One clip plane: positive corner select, registered products, plane test.
// ----------------------------------------------------------------------------
module tfc_plane_lane
  import tfc_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  box_t               box,
  input  logic [PLANE_W-1:0] plane,
  output logic               pass
);

  logic signed [NORM_W-1:0]   nx;
  logic signed [NORM_W-1:0]   ny;
  logic signed [NORM_W-1:0]   nz;
  logic signed [OFFSET_W-1:0] w;
  logic signed [COORD_W-1:0]  px;
  logic signed [COORD_W-1:0]  pz;
  logic signed [PROD_W-1:0]   py;
  logic signed [PROD_W-1:0]   prod_x;
  logic signed [PROD_W-1:0]   prod_y;
  logic signed [PROD_W-1:0]   prod_z;
  logic signed [OFFSET_W-1:0] w_q;
  logic signed [SUM_W-1:0]    plane_sum;

  assign nx = plane[NORM_W-1:0];
  assign ny = plane[2*NORM_W-1:NORM_W];
  assign nz = plane[3*NORM_W-1:2*NORM_W];
  assign w  = plane[PLANE_W-1:3*NORM_W];

  // A zero normal component picks the minimum edge.
  assign px = (nx > 0) ? box.max_x : box.min_x;
  assign py = (ny > 0) ? BOX_Y_MAX : BOX_Y_MIN;
  assign pz = (nz > 0) ? box.max_z : box.min_z;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_x <= PROD_W'(nx) * PROD_W'(px);
      prod_y <= PROD_W'(ny) * py;
      prod_z <= PROD_W'(nz) * PROD_W'(pz);
      w_q    <= w;
    end
  end

  // The offset is doubled to match the doubled coordinates.
  assign plane_sum = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z) + (SUM_W'(w_q) <<< 1);
  assign pass = (plane_sum >= CULL_LIMIT);

endmodule

[rtl/tile_frustum_cull_and_lod_select_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_frustum_cull_and_lod_select_top
// Tests a ground tile's box against six clip planes and flags near tiles.
// ----------------------------------------------------------------------------
// The block takes one tile word every clock cycle as long as the output is not
// stalled, and returns one result word per tile, in order. A tile moves from
// the input register that forms the box edges to the per-plane product
// registers (six lanes, three multipliers each), and the plane sums and
// compares land in the output register that drives out_valid. Stages advance
// on their own, so bubbles close up while the output stalls. Plane registers
// reset to zero, which makes every tile visible; writes to indexes past the
// far plane are ignored. Planes should be written only while no tile is in
// flight.
module tile_frustum_cull_and_lod_select_top
  import tfc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [TILE_W-1:0] tile_x,
  input  logic signed [TILE_W-1:0] tile_z,
  input  logic signed [TILE_W-1:0] camera_tile_x,
  input  logic signed [TILE_W-1:0] camera_tile_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     visible,
  output logic                     high_detail,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [PLANE_W-1:0]       cfg_data
);

`include "tile_frustum_cull_and_lod_select_top_assert.svh"

  logic [PLANE_W-1:0]     planes [PLANE_COUNT];
  logic                   v0;
  logic                   v1;
  logic                   r0;
  logic                   r1;
  logic                   r2;
  logic                   load0;
  logic                   load1;
  logic                   load2;
  box_t                   box;
  logic                   near0;
  logic                   near1;
  logic [PLANE_COUNT-1:0] pass;
  logic                   cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index <= FAR_PLANE);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANE_COUNT; i++) begin
        planes[i] <= '0;
      end
    end else if (cfg_hit) begin
      planes[cfg_index] <= cfg_data;
    end
  end

  // Each stage takes a new word when it is empty or its word moves on.
  assign r2       = !out_valid || out_ready;
  assign r1       = !v1 || r2;
  assign r0       = !v0 || r1;
  assign in_ready = r0;
  assign load0    = in_valid && r0;
  assign load1    = v0 && r1;
  assign load2    = v1 && r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r0) begin
        v0 <= in_valid;
      end
      if (r1) begin
        v1 <= v0;
      end
      if (r2) begin
        out_valid <= v1;
      end
    end
  end

  tfc_box_stage u_box (
    .clk           (clk),
    .load          (load0),
    .tile_x        (tile_x),
    .tile_z        (tile_z),
    .camera_tile_x (camera_tile_x),
    .camera_tile_z (camera_tile_z),
    .box           (box),
    .near_cam      (near0)
  );

  for (genvar gi = 0; gi < PLANE_COUNT; gi++) begin : g_lane
    tfc_plane_lane u_lane (
      .clk   (clk),
      .load  (load1),
      .box   (box),
      .plane (planes[gi]),
      .pass  (pass[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      near1 <= near0;
    end
    if (load2) begin
      visible     <= &pass;
      high_detail <= near1;
    end
  end

  `TFC_ASSERT_NEXT(a_s0_moves, v0 && r1, v1)
  `TFC_ASSERT_NEXT(a_s1_moves, v1 && r2, out_valid)
  `TFC_ASSERT_NEXT(a_cfg_write, cfg_hit, planes[$past(cfg_index)] == $past(cfg_data))

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks tile culling and detail selection against an in-bench predictor.
// ----------------------------------------------------------------------------
// A directed opening covers the coordinate extremes, the detail radius edges
// and a plane that sits exactly on the cull limit. Random phases then load
// several plane sets (all ones, field extremes, raw random, and planes aimed
// near the origin) and push bursts of tiles while the output side stalls.
// Each result word is checked in order against the predicted verdict.
module tb_top;
  import tfc_pkg::*;

  localparam int LONG_HOLD = 400;
  // Indexes past the far plane, which the block must ignore.
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = CFG_IDX_W'(PLANE_COUNT);
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = CFG_IDX_W'(PLANE_COUNT + 1);

  typedef struct packed {
    logic visible;
    logic high_detail;
  } tile_verdict_t;

  class cull_checker;
    logic [PLANE_W-1:0] planes [PLANE_COUNT];
    tile_verdict_t      verdicts_due [$];
    int                 faults;

    function new();
      foreach (planes[i]) planes[i] = '0;
      faults = 0;
    endfunction

    function void load_plane(logic [CFG_IDX_W-1:0] idx, logic [PLANE_W-1:0] data);
      if (idx < PLANE_COUNT) planes[idx] = data;
    endfunction

    function void predict_tile(logic signed [TILE_W-1:0] tx, logic signed [TILE_W-1:0] tz,
                               logic signed [TILE_W-1:0] cx, logic signed [TILE_W-1:0] cz);
      longint lo_x, hi_x, lo_z, hi_z, nx, ny, nz, w, px, py, pz, dot, dx, dz;
      tile_verdict_t v;
      // Box edges in doubled world units.
      lo_x = 2 * longint'(tx) * TILE_WORLD_SIZE - TILE_WORLD_SIZE;
      hi_x = 2 * longint'(tx) * TILE_WORLD_SIZE + TILE_WORLD_SIZE;
      lo_z = 2 * longint'(tz) * TILE_WORLD_SIZE - TILE_WORLD_SIZE;
      hi_z = 2 * longint'(tz) * TILE_WORLD_SIZE + TILE_WORLD_SIZE;
      v.visible = 1'b1;
      foreach (planes[i]) begin
        nx = longint'($signed(planes[i][11:0]));
        ny = longint'($signed(planes[i][23:12]));
        nz = longint'($signed(planes[i][35:24]));
        w  = longint'($signed(planes[i][63:36]));
        px = (nx > 0) ? hi_x : lo_x;
        py = (ny > 0) ? 2 * BOX_HALF_HEIGHT : -2 * BOX_HALF_HEIGHT;
        pz = (nz > 0) ? hi_z : lo_z;
        dot = nx * px + ny * py + nz * pz + 2 * w;
        if (dot < -longint'(TILE_WORLD_SIZE) * 512) v.visible = 1'b0;
      end
      dx = longint'(tx) - longint'(cx);
      dz = longint'(tz) - longint'(cz);
      v.high_detail = (dx <= LOD_RADIUS && dx >= -LOD_RADIUS &&
                       dz <= LOD_RADIUS && dz >= -LOD_RADIUS);
      verdicts_due.push_back(v);
    endfunction

    function void check_verdict(logic vis, logic hd);
      tile_verdict_t want;
      if (verdicts_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: result %0b/%0b arrived with no tile pending", $time, vis, hd);
        return;
      end
      want = verdicts_due.pop_front();
      if (want.visible !== vis || want.high_detail !== hd) begin
        faults++;
        if (faults <= 10)
          $display("%0t: visible/high_detail expected %0b/%0b, got %0b/%0b",
                   $time, want.visible, want.high_detail, vis, hd);
      end
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [TILE_W-1:0] tile_x = '0;
  logic signed [TILE_W-1:0] tile_z = '0;
  logic signed [TILE_W-1:0] camera_tile_x = '0;
  logic signed [TILE_W-1:0] camera_tile_z = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     visible;
  logic                     high_detail;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [PLANE_W-1:0]       cfg_data = '0;

  logic [PLANE_W-1:0] plane_set [PLANE_COUNT];
  bit                 hold_request = 1'b0;
  cull_checker        board = new();

  tile_frustum_cull_and_lod_select_top u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .tile_x        (tile_x),
    .tile_z        (tile_z),
    .camera_tile_x (camera_tile_x),
    .camera_tile_z (camera_tile_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .visible       (visible),
    .high_detail   (high_detail),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // All handshakes are observed here, so the order of checks is fixed.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_verdict(visible, high_detail);
      if (in_valid && in_ready) board.predict_tile(tile_x, tile_z, camera_tile_x, camera_tile_z);
      if (cfg_valid && cfg_ready) board.load_plane(cfg_index, cfg_data);
    end
  end

  // Output side: stall patterns of random length, plus one long hold on request.
  initial begin : out_side
    int hold_left;
    int mode;
    int span;
    hold_left = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(posedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
          out_ready <= 1'b0;
          hold_left--;
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("[tile_frustum_cull_and_lod_select_top] ERROR");
    $finish;
  end

  function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int w);
    return {28'(w), 12'(nz), 12'(ny), 12'(nx)};
  endfunction

  // Plane through a random point near the origin, turned so the origin is inside.
  function automatic logic [PLANE_W-1:0] aimed_plane();
    int nx, ny, nz, qx, qz, w;
    nx = $urandom_range(0, 1023) - 512;
    ny = $urandom_range(0, 1023) - 512;
    nz = $urandom_range(0, 1023) - 512;
    if ($urandom_range(0, 5) == 0) nx = 0;
    if ($urandom_range(0, 5) == 0) ny = 0;
    if ($urandom_range(0, 5) == 0) nz = 0;
    qx = $urandom_range(0, 12288) - 6144;
    qz = $urandom_range(0, 12288) - 6144;
    w = -(nx * qx + nz * qz) / 2 + ($urandom_range(0, 32767) - 16384);
    if (w < 0) begin
      nx = -nx;
      ny = -ny;
      nz = -nz;
      w = -w;
    end
    return pack_plane(nx, ny, nz, w);
  endfunction

  function automatic int pick_norm_extreme();
    case ($urandom_range(0, 2))
      0: return -2048;
      1: return 0;
      default: return 2047;
    endcase
  endfunction

  function automatic logic [PLANE_W-1:0] extreme_plane();
    int w;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {1'b1, 63'd0};
      2: return {1'b0, {63{1'b1}}};
      default: begin
        case ($urandom_range(0, 2))
          0: w = -(1 << 27);
          1: w = 0;
          default: w = (1 << 27) - 1;
        endcase
        return pack_plane(pick_norm_extreme(), pick_norm_extreme(), pick_norm_extreme(), w);
      end
    endcase
  endfunction

  task automatic send_tile(int tx, int tz, int cx, int cz);
    in_valid      <= 1'b1;
    tile_x        <= TILE_W'(tx);
    tile_z        <= TILE_W'(tz);
    camera_tile_x <= TILE_W'(cx);
    camera_tile_z <= TILE_W'(cz);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits out every pending result, then waits on past the pipeline depth.
  task automatic drain();
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_planes(bit poke_spare);
    cfg_valid <= 1'b1;
    if (poke_spare) begin
      cfg_index <= $urandom_range(0, 1) ? SPARE_IDX_HI : SPARE_IDX_LO;
      cfg_data  <= {$urandom, $urandom};
      do @(posedge clk); while (!cfg_ready);
    end
    for (int i = 0; i < PLANE_COUNT; i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= plane_set[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_tile(int near_pct);
    int tx, tz, cx, cz;
    if ($urandom_range(1, 100) <= near_pct) begin
      tx = $urandom_range(0, 24) - 12;
      tz = $urandom_range(0, 24) - 12;
    end else begin
      tx = $urandom_range(0, 4095);
      tz = $urandom_range(0, 4095);
    end
    if ($urandom_range(0, 1)) begin
      cx = tx + $urandom_range(0, 6) - 3;
      cz = tz + $urandom_range(0, 6) - 3;
    end else begin
      cx = $urandom_range(0, 4095);
      cz = $urandom_range(0, 4095);
    end
    send_tile(tx, tz, cx, cz);
  endtask

  // Bursts of tiles with random gaps; a steady sender adds no gaps, but may still drain.
  task automatic run_tiles(int count, int near_pct, bit steady);
    int sent, burst, gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_random_tile(near_pct);
        sent++;
      end
      gap = steady ? 0 : $urandom_range(0, 3) * $urandom_range(0, 8);
      if ($urandom_range(0, 30) == 0) begin
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
      end else if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    stop_sending();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Planes at reset: everything visible, detail radius edges and extremes.
    send_tile(0, 0, 0, 0);
    send_tile(2047, 2047, 2047, 2047);
    send_tile(-2048, -2048, -2048, -2048);
    send_tile(2047, -2048, -2048, 2047);
    send_tile(-2048, 2047, 2047, -2048);
    send_tile(2, -2, 0, 0);
    send_tile(3, 0, 0, 0);
    send_tile(0, -3, 0, 0);
    send_tile(-2, 2, 0, 0);
    send_tile(5, 7, 3, 9);
    send_tile(0, 0, -3, 0);
    stop_sending();
    drain();

    // A flat plane whose value sits exactly on the cull limit still passes.
    foreach (plane_set[i]) plane_set[i] = '0;
    plane_set[LEFT_PLANE] = pack_plane(0, 0, 0, -TILE_WORLD_SIZE * 256);
    load_planes(1'b1);
    send_tile(0, 0, 0, 0);
    send_tile(2047, -2048, 0, 0);
    stop_sending();
    drain();
    // One step further down and every tile is culled.
    plane_set[LEFT_PLANE] = pack_plane(0, 0, 0, -TILE_WORLD_SIZE * 256 - 1);
    load_planes(1'b1);
    send_tile(0, 0, 0, 0);
    send_tile(-2048, 2047, 0, 0);
    stop_sending();
    drain();

    // Largest normals, one axis per plane.
    plane_set[LEFT_PLANE]   = pack_plane(2047, 0, 0, 0);
    plane_set[RIGHT_PLANE]  = pack_plane(-2048, 0, 0, 0);
    plane_set[BOTTOM_PLANE] = pack_plane(0, 2047, 0, 0);
    plane_set[TOP_PLANE]    = pack_plane(0, -2048, 0, 0);
    plane_set[NEAR_PLANE]   = pack_plane(0, 0, 2047, 0);
    plane_set[FAR_PLANE]    = pack_plane(0, 0, -2048, (1 << 27) - 1);
    load_planes(1'b0);
    send_tile(0, 0, 0, 0);
    send_tile(-2048, 0, 0, 0);
    send_tile(2047, 0, 0, 0);
    send_tile(0, -2048, 0, 0);
    send_tile(0, 2047, 0, 0);
    stop_sending();
    drain();

    foreach (plane_set[i]) plane_set[i] = {PLANE_W{1'b1}};
    load_planes(1'b0);
    run_tiles(200, 50, 1'b0);
    drain();

    foreach (plane_set[i]) plane_set[i] = extreme_plane();
    load_planes(1'b1);
    run_tiles(200, 50, 1'b0);
    drain();

    foreach (plane_set[i]) plane_set[i] = {$urandom, $urandom};
    load_planes(1'b1);
    run_tiles(200, 50, 1'b0);
    drain();

    // The output holds off while tiles keep coming, so the input must stall.
    foreach (plane_set[i]) plane_set[i] = aimed_plane();
    load_planes(1'b0);
    hold_request = 1'b1;
    run_tiles(225, 85, 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      foreach (plane_set[i]) plane_set[i] = aimed_plane();
      load_planes(1'($urandom_range(0, 1)));
      run_tiles(225, 85, 1'b0);
      drain();
    end

    repeat (8) @(posedge clk);
    if (board.faults == 0) begin
      $display("[tile_frustum_cull_and_lod_select_top] OK");
    end else begin
      $display("[tile_frustum_cull_and_lod_select_top] ERROR");
    end
    $finish;
  end

endmodule
